// ----- hw/rtl/iirdf1_pkg.sv -----
package iirdf1_pkg;

  localparam int MaxOrder = 8;

  localparam int CoefW   = 32;
  localparam int SampW   = 16;
  localparam int OrderW  = 4;
  localparam int IdxW    = 4;
  localparam int CmdW    = 2;
  localparam int TapW    = $clog2(MaxOrder + 1);
  localparam int OhIdxW  = (MaxOrder > 1) ? $clog2(MaxOrder) : 1;
  localparam int ProdW   = CoefW + SampW;
  localparam int AccW    = ProdW + $clog2(2 * MaxOrder + 1) + 1;
  localparam int FracW   = 24;
  localparam int QW      = AccW - FracW;

  localparam int InDataW  = ((IdxW + CoefW + SampW + 7) / 8) * 8;
  localparam int OutDataW = ((SampW + 7) / 8) * 8;

  localparam logic [OrderW-1:0] OrderRst = OrderW'(2);

  localparam int AddrW = 3;
  localparam int DataW = 32;

  typedef enum logic [CmdW-1:0] {
    CmdFilter = 2'd0,
    CmdWrNum  = 2'd1,
    CmdWrDen  = 2'd2,
    CmdClear  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StMac   = 4'b0010,
    StDrain = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  typedef struct packed {
    logic            accept;
    logic            mul_en;
    logic            den;
    logic [TapW-1:0] tap;
    logic            finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/iirdf1_ctrl.sv -----
module iirdf1_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [iirdf1_pkg::CmdW-1:0]       in_cmd_i,
  output logic                              in_ready_o,
  input  logic [iirdf1_pkg::TapW-1:0]       order_i,
  input  iirdf1_pkg::dp_sts_t               sts_i,
  output iirdf1_pkg::dp_cmd_t               cmd_o
);
  import iirdf1_pkg::*;

  state_e          state_q, state_d;
  logic [TapW-1:0] tap_q, tap_d;
  logic            den_q, den_d;
  logic            acc_in;

  assign in_ready_o = (state_q == StIdle);
  assign acc_in     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    den_d   = den_q;
    unique case (state_q)
      StIdle: begin
        if (acc_in && (cmd_e'(in_cmd_i) == CmdFilter)) begin
          state_d = StMac;
          tap_d   = '0;
          den_d   = 1'b0;
        end
      end
      StMac: begin
        if (tap_q == '0) begin
          if (order_i == '0) begin
            state_d = StDrain;
          end else begin
            tap_d = TapW'(1);
          end
        end else if (!den_q) begin
          den_d = 1'b1;
        end else if (tap_q == order_i) begin
          state_d = StDrain;
        end else begin
          tap_d = tap_q + TapW'(1);
          den_d = 1'b0;
        end
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o.accept = acc_in;
    cmd_o.mul_en = (state_q == StMac);
    cmd_o.den    = den_q;
    cmd_o.tap    = tap_q;
    cmd_o.finish = (state_q == StDone) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tap_q   <= '0;
      den_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      den_q   <= den_d;
    end
  end

endmodule

// ----- hw/rtl/iirdf1_dp.sv -----
module iirdf1_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  iirdf1_pkg::dp_cmd_t               cmd_i,
  output iirdf1_pkg::dp_sts_t               sts_o,
  input  logic [iirdf1_pkg::TapW-1:0]       order_i,
  input  logic [iirdf1_pkg::CmdW-1:0]       in_cmd_i,
  input  logic [iirdf1_pkg::IdxW-1:0]       coef_index_i,
  input  logic signed [iirdf1_pkg::CoefW-1:0] coef_value_i,
  input  logic signed [iirdf1_pkg::SampW-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [iirdf1_pkg::SampW-1:0] sample_out_o,
  output logic                              saturated_o
);
  import iirdf1_pkg::*;

  logic signed [CoefW-1:0] b_q [MaxOrder+1];
  logic signed [CoefW-1:0] a_q [MaxOrder+1];
  logic signed [SampW-1:0] ih_q [MaxOrder+1];
  logic signed [SampW-1:0] oh_q [MaxOrder];

  logic signed [CoefW-1:0] mul_c;
  logic signed [SampW-1:0] mul_s;
  logic [TapW-1:0]         tap_m1;
  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q, prod_neg_q;
  logic signed [AccW-1:0]  acc_q, acc_d, prod_ext;

  logic signed [AccW-1:0]  rnd;
  logic signed [QW-1:0]    q_full;
  logic                    sat;
  logic signed [SampW-1:0] q_sat;

  logic                    out_valid_q;
  logic signed [SampW-1:0] sample_out_q;
  logic                    saturated_q;
  logic                    wr_num, wr_den, idx_ok, do_clear, do_filter;

  assign tap_m1 = cmd_i.tap - TapW'(1);
  assign mul_c  = cmd_i.den ? a_q[cmd_i.tap] : b_q[cmd_i.tap];
  assign mul_s  = cmd_i.den ? oh_q[tap_m1[OhIdxW-1:0]] : ih_q[cmd_i.tap];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= mul_c * mul_s;
      prod_neg_q <= cmd_i.den;
    end
  end

  // accumulate one product per cycle
  assign prod_ext = AccW'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.accept) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = prod_neg_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // round half up, then clip to q1.15
  assign rnd    = acc_q + AccW'(64'sd1 <<< (FracW - 1));
  assign q_full = rnd[AccW-1:FracW];
  assign sat    = (q_full[QW-1:SampW-1] != '0) && (q_full[QW-1:SampW-1] != '1);

  always_comb begin
    if (!sat) begin
      q_sat = q_full[SampW-1:0];
    end else if (q_full[QW-1]) begin
      q_sat = {1'b1, {(SampW-1){1'b0}}};
    end else begin
      q_sat = {1'b0, {(SampW-1){1'b1}}};
    end
  end

  assign do_filter = cmd_i.accept && (cmd_e'(in_cmd_i) == CmdFilter);
  assign idx_ok    = (coef_index_i <= IdxW'(MaxOrder));
  assign wr_num    = cmd_i.accept && (cmd_e'(in_cmd_i) == CmdWrNum) && idx_ok;
  assign wr_den    = cmd_i.accept && (cmd_e'(in_cmd_i) == CmdWrDen) && idx_ok;
  assign do_clear  = cmd_i.accept && (cmd_e'(in_cmd_i) == CmdClear);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MaxOrder; i++) begin
        b_q[i] <= '0;
        a_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i <= MaxOrder; i++) begin
        if (wr_num && (coef_index_i == IdxW'(i))) begin
          b_q[i] <= coef_value_i;
        end
        if (wr_den && (coef_index_i == IdxW'(i))) begin
          a_q[i] <= coef_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MaxOrder; i++) begin
        ih_q[i] <= '0;
      end
    end else if (do_clear) begin
      for (int i = 0; i <= MaxOrder; i++) begin
        ih_q[i] <= '0;
      end
    end else if (do_filter) begin
      ih_q[0] <= sample_in_i;
      for (int i = 1; i <= MaxOrder; i++) begin
        if (TapW'(i) <= order_i) begin
          ih_q[i] <= ih_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxOrder; i++) begin
        oh_q[i] <= '0;
      end
    end else if (do_clear) begin
      for (int i = 0; i < MaxOrder; i++) begin
        oh_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      oh_q[0] <= q_sat;
      for (int i = 1; i < MaxOrder; i++) begin
        if (TapW'(i) < order_i) begin
          oh_q[i] <= oh_q[i-1];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_out_q <= q_sat;
      saturated_q  <= sat;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_out_q;
  assign saturated_o    = saturated_q;

endmodule

// ----- hw/rtl/iir_direct_form_one_filter.sv -----
// channel      dir  tdata                                    tuser
// s_axis       in   coef_index, coef_value, sample_in        command
// m_axis       out  sample_out                               saturated
// apb          in   filter_order at byte address 0           -
//
// a filter beat walks N = min(filter_order, 8) taps through the single
// shared multiplier that forms one product per cycle
// coefficient write and clear beats act on acceptance and leave the block idle
// reset clears coefficients and histories and sets filter_order to 2
// one result waits in the output register while the next beat is taken;
// a later result holds in the last step until that register frees
module iir_direct_form_one_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [iirdf1_pkg::InDataW-1:0]      s_axis_tdata,  // coef_index, coef_value, sample_in
  input  logic [iirdf1_pkg::CmdW-1:0]         s_axis_tuser,  // command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [iirdf1_pkg::OutDataW-1:0]     m_axis_tdata,  // sample_out
  output logic                                m_axis_tuser,  // saturated
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iirdf1_pkg::AddrW-1:0]        paddr,
  input  logic [iirdf1_pkg::DataW-1:0]        pwdata,
  output logic [iirdf1_pkg::DataW-1:0]        prdata,
  output logic                                pready
);
  import iirdf1_pkg::*;

  logic [OrderW-1:0]        order_q;
  logic [TapW-1:0]          order_eff;
  logic                     reg_sel;
  dp_cmd_t                  dp_cmd;
  dp_sts_t                  dp_sts;
  logic signed [SampW-1:0]  sample_out;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1:2] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderRst;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      order_q <= pwdata[OrderW-1:0];
    end
  end

  assign prdata    = reg_sel ? DataW'(order_q) : '0;
  assign order_eff = (order_q > OrderW'(MaxOrder)) ? TapW'(MaxOrder) : TapW'(order_q);

  iirdf1_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .order_i    (order_eff),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  iirdf1_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .order_i      (order_eff),
    .in_cmd_i     (s_axis_tuser),
    .coef_index_i (s_axis_tdata[IdxW-1:0]),
    .coef_value_i (s_axis_tdata[IdxW+CoefW-1:IdxW]),
    .sample_in_i  (s_axis_tdata[IdxW+CoefW+SampW-1:IdxW+CoefW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sample_out_o (sample_out),
    .saturated_o  (m_axis_tuser)
  );

  assign m_axis_tdata = OutDataW'(sample_out);

  a_filter_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (cmd_e'(s_axis_tuser) == CmdFilter))
      |=> dp_cmd.mul_en)
    else $error("filter beat did not start the product walk");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.mul_en |-> !s_axis_tready)
    else $error("input taken while products are in flight");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending beat");

endmodule

// ----- sim/iir_direct_form_one_filter_tb.sv -----
module iir_direct_form_one_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iirdf1_pkg::*;

  localparam int TotalBeats = 1950;
  localparam int DrainCycles = 2 * MaxOrder + 16;
  localparam int CycleLimit = 1000000;
  localparam logic [AddrW-1:0] RegFilterOrder = AddrW'(0);

  typedef struct {
    logic [SampW-1:0] sample;
    logic             sat;
  } filt_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // coef_index, coef_value, sample_in
  logic [CmdW-1:0]     s_axis_tuser;   // command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // sample_out
  logic                m_axis_tuser;   // saturated
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // filter state as the block should hold it
  logic [CoefW-1:0]        b_coef [0:MaxOrder];
  logic [CoefW-1:0]        a_coef [0:MaxOrder];
  logic signed [SampW-1:0] x_hist [0:MaxOrder];
  logic signed [SampW-1:0] y_hist [0:MaxOrder-1];
  logic [OrderW-1:0]       order_set;

  filt_out_t pending_out[$];
  int        err_count;
  int        beats_sent;
  int        cycle_count;
  int        hold_req;
  int        sink_wait;
  bit        src_calm;
  bit        sink_calm;

  iir_direct_form_one_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one beat through the filter: updates state, queues the output sample if any
  function automatic void iir_step(cmd_e cmd, logic [IdxW-1:0] idx, logic [CoefW-1:0] coef,
                                   logic [SampW-1:0] samp);
    int        n;
    int        i;
    longint    acc;
    longint    q;
    filt_out_t res;
    case (cmd)
      CmdWrNum: begin
        if (idx <= MaxOrder) b_coef[idx] = coef;
      end
      CmdWrDen: begin
        if (idx <= MaxOrder) a_coef[idx] = coef;
      end
      CmdClear: begin
        foreach (x_hist[k]) x_hist[k] = '0;
        foreach (y_hist[k]) y_hist[k] = '0;
      end
      default: begin
        n = (order_set > MaxOrder) ? MaxOrder : int'(order_set);
        for (i = n; i > 0; i--) x_hist[i] = x_hist[i-1];
        x_hist[0] = samp;
        acc = longint'($signed(b_coef[0])) * longint'(x_hist[0]);
        for (i = 1; i <= n; i++) begin
          acc += longint'($signed(b_coef[i])) * longint'(x_hist[i]);
          acc -= longint'($signed(a_coef[i])) * longint'(y_hist[i-1]);
        end
        acc += longint'(1) <<< (FracW - 1);
        q = acc >>> FracW;
        res.sat = 1'b0;
        if (q > 32767) begin
          q = 32767;
          res.sat = 1'b1;
        end else if (q < -32768) begin
          q = -32768;
          res.sat = 1'b1;
        end
        for (i = n - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
        y_hist[0] = q[SampW-1:0];
        res.sample = q[SampW-1:0];
        pending_out.push_back(res);
      end
    endcase
  endfunction

  task automatic send_beat(cmd_e cmd, logic [IdxW-1:0] idx, logic [CoefW-1:0] coef,
                           logic [SampW-1:0] samp);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({samp, coef, idx});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    iir_step(cmd, idx, coef, samp);
    beats_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_order(logic [OrderW-1:0] ord);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegFilterOrder;
    pwdata  <= {(DataW - OrderW)'($urandom), ord};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    order_set = ord;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // output side: random stalls, calm stretches, and a long hold on request
  always @(posedge clk_i) begin : sink_drive
    int g;
    if (hold_req > 0) begin
      sink_wait = hold_req;
      hold_req = 0;
    end
    if (sink_wait > 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else if (sink_calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      g = pick_gap();
      m_axis_tready <= (g == 0);
      sink_wait = (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk_i) begin : out_check
    filt_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected output beat: sample_out %h saturated %b",
                   m_axis_tdata[SampW-1:0], m_axis_tuser);
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata[SampW-1:0] !== want.sample) begin
          err_count++;
          if (err_count <= 10)
            $display("sample_out mismatch: expected %h actual %h",
                     want.sample, m_axis_tdata[SampW-1:0]);
        end
        if (m_axis_tuser !== want.sat) begin
          err_count++;
          if (err_count <= 10)
            $display("saturated mismatch: expected %b actual %b", want.sat, m_axis_tuser);
        end
      end
    end
  end

  function automatic logic [SampW-1:0] rand_sample(bit quiet);
    return quiet ? SampW'($urandom_range(0, 4095) - 2048) : SampW'($urandom);
  endfunction

  function automatic logic [CoefW-1:0] rand_coef(bit wild);
    return wild ? CoefW'($urandom) : CoefW'($urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
  endfunction

  task automatic test_directed();
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h1234);          // all coefficients zero
    send_beat(CmdWrNum, 4'd0, 32'h0100_0000, 16'h0);      // b0 = 1.0
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h7fff);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h8000);
    send_beat(CmdWrNum, 4'hf, 32'h0, 16'h0);              // index out of range
    send_beat(CmdWrNum, 4'h9, 32'h0, 16'h0);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h0001);
    send_beat(CmdWrNum, 4'd0, 32'h7fff_ffff, 16'h0);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h7fff);          // clip high
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h8000);          // clip low
    send_beat(CmdWrNum, 4'd0, 32'h8000_0000, 16'h0);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h8000);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h7fff);
    send_beat(CmdWrNum, 4'd0, 32'h0080_0000, 16'h0);      // b0 = 0.5, ties
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h0001);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'hffff);
    send_beat(CmdWrDen, 4'd0, 32'hffff_ffff, 16'h0);      // a0 is never used
    send_beat(CmdWrDen, 4'd1, 32'h0080_0000, 16'h0);
    send_beat(CmdWrNum, 4'd2, 32'hff00_0000, 16'h0);
    send_beat(CmdWrDen, 4'd8, 32'h0000_0001, 16'h0);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h4000);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'hc000);
    send_beat(CmdClear, 4'd0, 32'h0, 16'h0);
    send_beat(CmdFilter, 4'd0, 32'h0, 16'h0000);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    src_calm = 1'b1;
    hold_req = 400;
    repeat (16) send_beat(CmdFilter, 4'd0, 32'h0, rand_sample(1'b0));
    src_calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_mix();
    int               seg;
    int               r;
    int               i;
    int               n;
    bit               wild;
    bit               quiet;
    logic [OrderW-1:0] ord;
    seg = 0;
    while (beats_sent < TotalBeats) begin
      if (seg < 4 || $urandom_range(0, 3) == 0) begin
        wait_idle();
        case (seg)
          0: ord = 4'd0;
          1: ord = 4'd8;
          2: ord = 4'd15;
          3: ord = 4'd1;
          default: begin
            r = $urandom_range(0, 9);
            if (r < 5) ord = OrderW'($urandom_range(1, 7));
            else if (r < 7) ord = 4'd8;
            else if (r < 8) ord = 4'd0;
            else ord = OrderW'($urandom_range(9, 15));
          end
        endcase
        write_order(ord);
      end
      src_calm  = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      wild  = ($urandom_range(0, 4) == 0);
      quiet = ($urandom_range(0, 2) == 0);
      if (seg < 4 || $urandom_range(0, 1) == 0) begin
        n = (order_set > MaxOrder) ? MaxOrder : int'(order_set);
        for (i = 0; i <= n; i++) begin
          send_beat(CmdWrNum, IdxW'(i), rand_coef(wild), rand_sample(1'b0));
          send_beat(CmdWrDen, IdxW'(i), rand_coef(wild), rand_sample(1'b0));
        end
      end
      repeat ($urandom_range(10, 60)) begin
        r = $urandom_range(0, 99);
        if (r < 85)
          send_beat(CmdFilter, IdxW'($urandom), CoefW'($urandom), rand_sample(quiet));
        else if (r < 88)
          send_beat(CmdClear, IdxW'($urandom), CoefW'($urandom), SampW'($urandom));
        else if (r < 94)
          send_beat($urandom_range(0, 1) ? CmdWrNum : CmdWrDen, IdxW'($urandom),
                    rand_coef(wild), SampW'($urandom));
        else
          send_beat(cmd_e'($urandom_range(0, 3)), IdxW'($urandom), CoefW'($urandom),
                    SampW'($urandom));
      end
      seg++;
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    wait_idle();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdFilter;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    err_count     = 0;
    beats_sent    = 0;
    cycle_count   = 0;
    hold_req      = 0;
    sink_wait     = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    foreach (b_coef[k]) b_coef[k] = '0;
    foreach (a_coef[k]) a_coef[k] = '0;
    foreach (x_hist[k]) x_hist[k] = '0;
    foreach (y_hist[k]) y_hist[k] = '0;
    order_set = OrderRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_output_backpressure();
    test_random_mix();

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
